FILE: hw/rtl/woi_pkg.sv
// ----------------------------------------------------------------------------
// Wheel odometry package
// Shared widths, register indexes, CORDIC table and the item type that
// crosses from the front end to the pose engine.
// ----------------------------------------------------------------------------
package woi_pkg;

   localparam int POSE_WIDTH   = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = 5;

   localparam logic signed [35:0] CORDIC_GAIN_Q30 = 36'sd652032874;
   localparam logic [31:0] TURNS_PER_RADIAN_Q32   = 32'd683565276;

   typedef enum logic [1:0] {
      MODE_OMNI  = 2'd0,
      MODE_SKID  = 2'd1,
      MODE_DIFF  = 2'd2,
      MODE_ZERO  = 2'd3
   } drive_mode_type;

   typedef enum logic [1:0] {
      REG_DRIVE_MODE = 2'd0,
      REG_RADIUS     = 2'd1,
      REG_INV_TRACK  = 2'd2,
      REG_INV_WPL    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_CORDIC,
      ST_ROTATE,
      ST_STEP,
      ST_HEAD,
      ST_SEND
   } back_state_type;

   // One classified item: wheel sums, the reciprocal to use, drive mode, radius and dt.
   typedef struct packed {
      logic signed [17:0] sum_x;
      logic signed [17:0] sum_y;
      logic signed [17:0] sum_t;
      logic [23:0]        inv_recip;
      logic [1:0]         mode;
      logic [15:0]        radius;
      logic [15:0]        dt;
   } item_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/wheel_odometry_integrator.sv
// ----------------------------------------------------------------------------
// Wheel odometry integrator
// Integrates four wheel speeds into a planar pose and heading.
// ----------------------------------------------------------------------------
// Usage: req_ carries four Q8.8 wheel speeds and dt; one transfer there gives
// exactly one transfer on rsp_ with the updated pose, heading and the body
// velocities. csr_ writes drive mode, wheel radius and the two reciprocals;
// write them only while the block is idle.
// A front end forms the wheel sums and queues up to two items; the pose
// engine works on one item at a time: it takes it from the queue, does the
// velocity scaling on the shared multiplier, 24 CORDIC rotations, the
// world rotation, the position step and the heading step, and then loads
// the result register. It takes no new item from the queue before it has
// loaded the result of the last one.
// Reset clears the pose and heading and loads the register reset values.
// When the receiver stalls, the result waits in its register, the engine
// finishes the next item and waits to load it, and the queue fills before
// req_tready drops.
// ----------------------------------------------------------------------------
module wheel_odometry_integrator import woi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // fields: front_left, front_right, back_left, back_right speed, elapsed_time
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fields: pose_x, pose_y, heading, vel_x, vel_y, vel_turn
   output logic [191:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   logic [1:0]  mode_ff;
   logic [15:0] radius_ff;
   logic [23:0] inv_track_ff, inv_wpl_ff;
   logic        item_valid, item_take;
   item_type    item;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ZERO;
         radius_ff    <= 16'd3277;
         inv_track_ff <= '0;
         inv_wpl_ff   <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_DRIVE_MODE: mode_ff      <= csr_wdata[1:0];
            REG_RADIUS:     radius_ff    <= csr_wdata[15:0];
            REG_INV_TRACK:  inv_track_ff <= csr_wdata;
            REG_INV_WPL:    inv_wpl_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   woi_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .drive_mode(mode_ff), .radius_q16(radius_ff),
      .inv_track_width(inv_track_ff), .inv_width_plus_length(inv_wpl_ff),
      .item_valid, .item_take, .item
   );

   woi_back u_back (
      .clock, .reset, .item_valid, .item_take, .item,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

FILE: hw/rtl/woi_front.sv
// ----------------------------------------------------------------------------
// Wheel odometry front end
// Takes input transfers, forms the wheel sums for the configured drive mode
// and writes one item into a two-entry queue.
// ----------------------------------------------------------------------------
module woi_front import woi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  drive_mode,
   input  logic [15:0] radius_q16,
   input  logic [23:0] inv_track_width,
   input  logic [23:0] inv_width_plus_length,
   output logic        item_valid,
   input  logic        item_take,
   output item_type    item
);

   item_type           q_ff [2];
   item_type           q_in;
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic signed [17:0] fl, fr, bl, br;
   logic               push, pop;

   assign fl = 18'(signed'(req_tdata[15:0]));
   assign fr = 18'(signed'(req_tdata[31:16]));
   assign bl = 18'(signed'(req_tdata[47:32]));
   assign br = 18'(signed'(req_tdata[63:48]));

   always_comb begin
      q_in           = '0;
      q_in.mode      = drive_mode;
      q_in.radius    = radius_q16;
      q_in.dt        = req_tdata[79:64];
      unique case (drive_mode_type'(drive_mode))
         MODE_OMNI: begin
            q_in.sum_x     = fl + fr + bl + br;
            q_in.sum_y     = -fl + fr + bl - br;
            q_in.sum_t     = -fl + fr - bl + br;
            q_in.inv_recip = inv_width_plus_length;
         end
         MODE_SKID: begin
            q_in.sum_x     = fl + fr + bl + br;
            q_in.sum_t     = fr + br - fl - bl;
            q_in.inv_recip = inv_track_width;
         end
         MODE_DIFF: begin
            q_in.sum_x     = bl + br;
            q_in.sum_t     = br - bl;
            q_in.inv_recip = inv_track_width;
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = item_take && item_valid;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule

FILE: hw/rtl/woi_back.sv
// ----------------------------------------------------------------------------
// Wheel odometry pose engine
// Scales wheel sums to body velocities, runs a CORDIC on the heading,
// rotates, scales by dt and updates the pose, one step of a shared
// multiplier per cycle.
// ----------------------------------------------------------------------------
module woi_back import woi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   output logic         item_take,
   input  item_type     item,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata
);

   back_state_type          state_ff, state_in;
   logic [3:0]              sub_ff, sub_in;
   logic [STEP_W-1:0]       step_ff;
   item_type                it_ff;
   logic signed [63:0]      prod_ff;
   logic signed [31:0]      vx_ff, vy_ff, vt_ff;
   logic signed [35:0]      cx_ff, cy_ff, cz_ff;
   logic signed [35:0]      cos_ff, sin_ff;
   logic signed [63:0]      acc_ff;
   logic signed [31:0]      wx_ff, wy_ff;
   logic [POSE_WIDTH-1:0]   px_ff, py_ff;
   logic [31:0]             hd_ff;
   logic signed [63:0]      p_ff;
   logic [191:0]            out_ff;
   logic                    out_valid_ff;

   logic signed [35:0]      xs, ys;
   logic signed [35:0]      mul_a, mul_b;
   logic signed [71:0]      mul_p;
   logic signed [63:0]      rnd;
   logic [5:0]              rsh;
   logic signed [63:0]      rounded;
   logic                    last_step;

   assign mul_p     = mul_a * mul_b;
   assign xs        = cx_ff >>> step_ff;
   assign ys        = cy_ff >>> step_ff;
   assign last_step = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign rounded   = (prod_ff + (64'sd1 <<< (rsh - 6'd1))) >>> rsh;

   // Multiplier operands and rounding shift per sub-step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      rsh   = 6'd16;
      case (state_ff)
         ST_SCALE: begin
            unique case (sub_ff)
               4'd0: begin
                  mul_a = 36'(it_ff.sum_x);
                  mul_b = 36'(signed'({1'b0, it_ff.radius}));
               end
               4'd2: begin
                  mul_a = 36'(it_ff.sum_y);
                  mul_b = 36'(signed'({1'b0, it_ff.radius}));
               end
               4'd4: begin
                  mul_a = 36'(it_ff.sum_t);
                  mul_b = 36'(signed'({1'b0, it_ff.radius}));
               end
               4'd5: begin
                  mul_a = 36'(prod_ff);
                  mul_b = 36'(signed'({1'b0, it_ff.inv_recip}));
               end
               default: begin
               end
            endcase
            unique case (drive_mode_type'(it_ff.mode))
               MODE_OMNI: rsh = (sub_ff == 4'd6) ? 6'd26 : 6'd10;
               MODE_SKID: rsh = (sub_ff == 4'd6) ? 6'd25 : 6'd10;
               MODE_DIFF: rsh = (sub_ff == 4'd6) ? 6'd24 : 6'd9;
               default:   rsh = 6'd10;
            endcase
         end
         ST_ROTATE: begin
            rsh = 6'd30;
            unique case (sub_ff)
               4'd0: begin mul_a = 36'(vx_ff); mul_b = cos_ff; end
               4'd1: begin mul_a = 36'(vy_ff); mul_b = -sin_ff; end
               4'd3: begin mul_a = 36'(vx_ff); mul_b = sin_ff; end
               4'd4: begin mul_a = 36'(vy_ff); mul_b = cos_ff; end
               default: begin
               end
            endcase
         end
         ST_STEP: begin
            unique case (sub_ff)
               4'd0: begin mul_a = 36'(wx_ff); mul_b = 36'(signed'({1'b0, it_ff.dt})); end
               4'd2: begin mul_a = 36'(wy_ff); mul_b = 36'(signed'({1'b0, it_ff.dt})); end
               4'd4: begin mul_a = 36'(vt_ff); mul_b = 36'(signed'({1'b0, it_ff.dt})); end
               default: begin
               end
            endcase
         end
         ST_HEAD: begin
            unique case (sub_ff)
               4'd0: begin
                  mul_a = 36'(p_ff >>> 16);
                  mul_b = 36'(signed'({1'b0, TURNS_PER_RADIAN_Q32}));
               end
               4'd1: begin
                  mul_a = 36'(signed'({1'b0, p_ff[15:0]}));
                  mul_b = 36'(signed'({1'b0, TURNS_PER_RADIAN_Q32}));
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rnd = rounded;

   // Next state.
   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      unique case (state_ff)
         ST_IDLE: begin
            sub_in = 4'd0;
            if (item_valid) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            sub_in = sub_ff + 4'd1;
            if (sub_ff == 4'd7) begin
               state_in = ST_CORDIC;
               sub_in   = 4'd0;
            end
         end
         ST_CORDIC: begin
            if (last_step) state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            sub_in = sub_ff + 4'd1;
            if (sub_ff == 4'd6) begin
               state_in = ST_STEP;
               sub_in   = 4'd0;
            end
         end
         ST_STEP: begin
            sub_in = sub_ff + 4'd1;
            if (sub_ff == 4'd5) begin
               state_in = ST_HEAD;
               sub_in   = 4'd0;
            end
         end
         ST_HEAD: begin
            sub_in = sub_ff + 4'd1;
            if (sub_ff == 4'd3) begin
               state_in = ST_SEND;
               sub_in   = 4'd0;
            end
         end
         ST_SEND: begin
            if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      item_take = (state_ff == ST_IDLE) && item_valid;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p[63:0];
      if (item_take) begin
         it_ff <= item;
      end
      case (state_ff)
         ST_SCALE: begin
            unique case (sub_ff)
               4'd1: vx_ff <= (it_ff.mode == MODE_ZERO) ? '0 : sat32(rnd);
               4'd3: vy_ff <= (it_ff.mode == MODE_OMNI) ? sat32(rnd) : '0;
               4'd6: vt_ff <= (it_ff.mode == MODE_ZERO) ? '0 : sat32(rnd);
               4'd7: begin
                  cx_ff   <= CORDIC_GAIN_Q30;
                  cy_ff   <= '0;
                  cz_ff   <= 36'({6'd0, hd_ff[29:0]});
                  step_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         ST_CORDIC: begin
            if (!cz_ff[35]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - 36'(atan_turn(step_ff));
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + 36'(atan_turn(step_ff));
            end
            step_ff <= step_ff + STEP_W'(1);
         end
         ST_ROTATE: begin
            unique case (sub_ff)
               4'd1: acc_ff <= prod_ff;
               4'd2: acc_ff <= acc_ff + prod_ff;
               4'd3: wx_ff  <= 32'((acc_ff + (64'sd1 <<< 29)) >>> 30);
               4'd4: acc_ff <= prod_ff;
               4'd5: acc_ff <= acc_ff + prod_ff;
               4'd6: wy_ff  <= 32'((acc_ff + (64'sd1 <<< 29)) >>> 30);
               default: begin
               end
            endcase
         end
         ST_STEP: begin
            unique case (sub_ff)
               4'd1: px_ff <= px_ff + POSE_WIDTH'(rnd);
               4'd3: py_ff <= py_ff + POSE_WIDTH'(rnd);
               4'd5: p_ff  <= prod_ff;
               default: begin
               end
            endcase
         end
         ST_HEAD: begin
            unique case (sub_ff)
               4'd1: acc_ff <= prod_ff;
               4'd2: acc_ff <= acc_ff + (prod_ff >>> 16) + 64'sd32768;
               4'd3: hd_ff  <= hd_ff + 32'(acc_ff >>> 16);
               default: begin
               end
            endcase
         end
         ST_SEND: begin
            if (!out_valid_ff || rsp_tready) begin
               out_ff <= {vt_ff, vy_ff, vx_ff, hd_ff, py_ff[31:0], px_ff[31:0]};
            end
         end
         default: begin
         end
      endcase
      // Quadrant fold applied in the same cycle as the last rotation, on its result.
      if (state_ff == ST_CORDIC && last_step) begin
         unique case (hd_ff[31:30])
            2'd0: begin
               cos_ff <= cx_ff - (cz_ff[35] ? -ys : ys);
               sin_ff <= cy_ff + (cz_ff[35] ? -xs : xs);
            end
            2'd1: begin
               cos_ff <= -(cy_ff + (cz_ff[35] ? -xs : xs));
               sin_ff <= cx_ff - (cz_ff[35] ? -ys : ys);
            end
            2'd2: begin
               cos_ff <= -(cx_ff - (cz_ff[35] ? -ys : ys));
               sin_ff <= -(cy_ff + (cz_ff[35] ? -xs : xs));
            end
            default: begin
               cos_ff <= cy_ff + (cz_ff[35] ? -xs : xs);
               sin_ff <= -(cx_ff - (cz_ff[35] ? -ys : ys));
            end
         endcase
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         hd_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         if (state_ff == ST_SEND && (!out_valid_ff || rsp_tready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |=> state_ff == ST_SCALE) else $error("item taken outside idle");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed");
   a_cordic_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC && !last_step |=> state_ff == ST_CORDIC)
      else $error("CORDIC left early");
`endif

endmodule
